@@ design/tsd_pkg.sv @@
`timescale 1ns / 1ps
// tsd_pkg: types and constants for the tar stream deframer
// no dependencies; imported by tar_stream_deframer

package tsd_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);

  localparam logic [OFF_W-1:0] BLOCK_LAST   = OFF_W'(BLOCK_BYTES - 1);
  localparam logic [OFF_W-1:0] SIZE_AT      = OFF_W'(124);
  localparam logic [OFF_W-1:0] SIZE_END     = OFF_W'(136);
  localparam logic [OFF_W-1:0] TYPE_AT      = OFF_W'(156);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int ENTRY_SIZE_W = 36;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_DATA   = 3'd1,
    PH_PAD    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_END    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CLS_HEADER = 3'd0,
    CLS_DATA   = 3'd1,
    CLS_PAD    = 3'd2,
    CLS_SKIP   = 3'd3,
    CLS_END    = 3'd4
  } byte_class_t;

  typedef enum logic [1:0] {
    SCAN_BLANK = 2'd0,
    SCAN_DIGIT = 2'd1,
    SCAN_DONE  = 2'd2
  } scan_t;

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_DIR   = 2'd1,
    KIND_OTHER = 2'd2
  } entry_kind_t;

  typedef enum logic [1:0] {
    BK_ENTRY = 2'd0,
    BK_ZERO  = 2'd1,
    BK_EOA   = 2'd2
  } block_kind_t;

endpackage

@@ design/tar_stream_deframer.sv @@
`timescale 1ns / 1ps
// tar_stream_deframer: tags each byte of a tar archive with its role
// depends on tsd_pkg

// Takes one archive byte per item and returns one tagged item per byte: the byte itself, its
// class (header, file content, padding, skipped content, after end), a flag on the last byte
// of every header block with the block kind, the kind and octal-decoded size of the latest entry, and
// a flag on the last content byte of a regular file. One item per cycle is sustained; each
// byte updates the parser state in the cycle it is accepted and its result lands in a single
// output register, so in_ready drops only while a held result waits on out_ready. The result
// is valid in the cycle after acceptance. After two consecutive all-zero blocks every
// further byte is tagged as after end until reset.
module tar_stream_deframer
  import tsd_pkg::*;
#(
  parameter int SIZE_BITS = 36
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_archive_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte_out,
  output logic [2:0]              out_byte_class,
  output logic                    out_header_end,
  output logic [1:0]              out_block_kind,
  output logic [1:0]              out_entry_kind,
  output logic [ENTRY_SIZE_W-1:0] out_entry_size,
  output logic                    out_content_last
);

  localparam int EXT_W = (SIZE_BITS > ENTRY_SIZE_W) ? SIZE_BITS : ENTRY_SIZE_W;

  phase_t                 phase_r, phase_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [SIZE_BITS-1:0]   rem_r, rem_nxt;
  logic [SIZE_BITS-1:0]   acc_r, acc_nxt;
  scan_t                  scan_r, scan_nxt;
  logic                   nz_r, nz_nxt;
  logic                   zseen_r, zseen_nxt;
  entry_kind_t            type_r, type_nxt;
  entry_kind_t            lat_kind_r, lat_kind_nxt;
  logic [SIZE_BITS-1:0]   lat_size_r, lat_size_nxt;

  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  byte_class_t            out_cls_r, cls;
  logic                   out_hend_r, hend;
  block_kind_t            out_bkind_r, bkind;
  entry_kind_t            out_kind_r;
  logic [SIZE_BITS-1:0]   out_size_r;
  logic                   out_clast_r, clast;

  logic                   accept;
  logic [7:0]             b;
  logic                   is_blank, is_digit, in_field, hdr_first, hdr_last;
  logic [SIZE_BITS-1:0]   acc_base, acc_cur, rem_dec;
  scan_t                  scan_base, scan_cur;
  logic                   nz_cur;
  entry_kind_t            type_cur;
  logic [OFF_W-1:0]       off_inc;
  logic [EXT_W-1:0]       size_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_archive_byte;

  assign is_blank  = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_digit  = (b[7:3] == CH_ZERO[7:3]);
  assign in_field  = (off_r >= SIZE_AT) && (off_r < SIZE_END);
  assign hdr_first = (off_r == '0);
  assign hdr_last  = (off_r == BLOCK_LAST);
  assign off_inc   = off_r + 1'b1;
  assign rem_dec   = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

  assign acc_base  = hdr_first ? '0 : acc_r;
  assign scan_base = hdr_first ? SCAN_BLANK : scan_r;
  assign nz_cur    = (hdr_first ? 1'b0 : nz_r) || (b != 8'h00);

  // octal size field scan
  always_comb begin
    acc_cur  = acc_base;
    scan_cur = scan_base;
    if (in_field) begin
      case (scan_base)
        SCAN_BLANK: begin
          if (is_digit) begin
            acc_cur  = SIZE_BITS'(b[2:0]);
            scan_cur = SCAN_DIGIT;
          end else if (!is_blank) begin
            scan_cur = SCAN_DONE;
          end
        end
        SCAN_DIGIT: begin
          if (is_digit) begin
            if (|acc_base[SIZE_BITS-1:SIZE_BITS-3]) begin
              acc_cur = '1;
            end else begin
              acc_cur = {acc_base[SIZE_BITS-4:0], b[2:0]};
            end
          end else begin
            scan_cur = SCAN_DONE;
          end
        end
        default: begin
          scan_cur = scan_base;
        end
      endcase
    end
  end

  // type byte
  always_comb begin
    type_cur = type_r;
    if (off_r == TYPE_AT) begin
      if (b == CH_ZERO || b == 8'h00) begin
        type_cur = KIND_REG;
      end else if (b == CH_FIVE) begin
        type_cur = KIND_DIR;
      end else begin
        type_cur = KIND_OTHER;
      end
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_last) begin
          if (nz_cur) begin
            if (type_cur == KIND_REG && acc_cur != '0) begin
              phase_nxt = PH_DATA;
            end else if (type_cur == KIND_OTHER && acc_cur != '0) begin
              phase_nxt = PH_SKIP;
            end
          end else if (zseen_r) begin
            phase_nxt = PH_END;
          end
        end
      end
      PH_DATA: begin
        if (rem_dec == '0) begin
          phase_nxt = (off_inc == '0) ? PH_HEADER : PH_PAD;
        end
      end
      PH_PAD: begin
        if (off_inc == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_SKIP: begin
        if (rem_dec == '0 && off_inc == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_END;
      end
    endcase
  end

  // datapath and result fields
  always_comb begin
    off_nxt      = off_inc;
    rem_nxt      = rem_r;
    acc_nxt      = acc_r;
    scan_nxt     = scan_r;
    nz_nxt       = nz_r;
    zseen_nxt    = zseen_r;
    type_nxt     = type_r;
    lat_kind_nxt = lat_kind_r;
    lat_size_nxt = lat_size_r;
    cls          = CLS_END;
    hend         = 1'b0;
    bkind        = BK_ENTRY;
    clast        = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        cls      = CLS_HEADER;
        acc_nxt  = acc_cur;
        scan_nxt = scan_cur;
        nz_nxt   = nz_cur;
        type_nxt = type_cur;
        if (hdr_last) begin
          hend = 1'b1;
          if (nz_cur) begin
            zseen_nxt    = 1'b0;
            lat_kind_nxt = type_cur;
            lat_size_nxt = acc_cur;
            rem_nxt      = acc_cur;
          end else if (zseen_r) begin
            bkind = BK_EOA;
          end else begin
            bkind     = BK_ZERO;
            zseen_nxt = 1'b1;
          end
        end
      end
      PH_DATA: begin
        cls     = CLS_DATA;
        rem_nxt = rem_dec;
        clast   = (rem_dec == '0);
      end
      PH_PAD: begin
        cls = CLS_PAD;
      end
      PH_SKIP: begin
        cls     = CLS_SKIP;
        rem_nxt = rem_dec;
      end
      default: begin
        cls     = CLS_END;
        off_nxt = off_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      off_r      <= '0;
      rem_r      <= '0;
      acc_r      <= '0;
      scan_r     <= SCAN_BLANK;
      nz_r       <= 1'b0;
      zseen_r    <= 1'b0;
      type_r     <= KIND_REG;
      lat_kind_r <= KIND_REG;
      lat_size_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      off_r      <= off_nxt;
      rem_r      <= rem_nxt;
      acc_r      <= acc_nxt;
      scan_r     <= scan_nxt;
      nz_r       <= nz_nxt;
      zseen_r    <= zseen_nxt;
      type_r     <= type_nxt;
      lat_kind_r <= lat_kind_nxt;
      lat_size_r <= lat_size_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r  <= b;
      out_cls_r   <= cls;
      out_hend_r  <= hend;
      out_bkind_r <= bkind;
      out_kind_r  <= lat_kind_nxt;
      out_size_r  <= lat_size_nxt;
      out_clast_r <= clast;
    end
  end

  assign size_ext = EXT_W'(out_size_r);

  assign out_valid        = out_valid_r;
  assign out_byte_out     = out_byte_r;
  assign out_byte_class   = out_cls_r;
  assign out_header_end   = out_hend_r;
  assign out_block_kind   = out_bkind_r;
  assign out_entry_kind   = out_kind_r;
  assign out_entry_size   = size_ext[ENTRY_SIZE_W-1:0];
  assign out_content_last = out_clast_r;

`ifndef SYNTHESIS
  a_hend_in_header : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_end |-> out_byte_class == CLS_HEADER)
    else $error("header_end outside a header block");

  a_clast_in_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_content_last |-> out_byte_class == CLS_DATA)
    else $error("content_last outside file content");

  a_bkind_only_at_hend : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_header_end |-> out_block_kind == BK_ENTRY)
    else $error("block_kind set away from header_end");

  a_end_sticks : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_END |=> phase_r == PH_END)
    else $error("left the after-end phase");
`endif

endmodule
